// ===== rtl/lpu_pkg.sv =====
// Shared types, constants and fixed-point helpers of the lens point undistortion unit.
package lpu_pkg;

    // Fixed-point formats.
    localparam int FRAC       = 30;
    localparam int COEF_FRAC  = 28;
    localparam int PASSES_DEF = 5;

    // Numerator widths of the two divider flavors.
    localparam int NORM_NUM_W = 55;
    localparam int PASS_NUM_W = 62;

    // Divider latency: magnitude stage, range stage, one stage per quotient bit, sign stage.
    localparam int QUO_W   = 32;
    localparam int DIV_LAT = QUO_W + 3;

    // Configuration register indexes.
    localparam logic [2:0] REG_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_K1 = 3'd4;
    localparam logic [2:0] REG_K2 = 3'd5;
    localparam logic [2:0] REG_P1 = 3'd6;
    localparam logic [2:0] REG_P2 = 3'd7;

    localparam logic [23:0] FOCAL_RESET = 24'd1048576;

    typedef logic signed [31:0] q30_t;

    localparam q30_t Q30_MAX = 32'sh7FFFFFFF;
    localparam q30_t Q30_MIN = 32'sh80000000;

    // Distortion coefficients, all signed Q3.28.
    typedef struct packed {
        q30_t k1;
        q30_t k2;
        q30_t p1;
        q30_t p2;
    } coef_t;

    // One point in flight between passes.
    typedef struct packed {
        logic valid;
        q30_t x;
        q30_t y;
        q30_t x0;
        q30_t y0;
    } pt_t;

    // Saturate a widened value to signed Q2.30.
    function automatic q30_t sat30(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return Q30_MAX;
        end else if (v < -40'sd2147483648) begin
            return Q30_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

    // Q2.30 product, floored back to 30 fraction bits and saturated.
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat30(40'($signed(p[63:FRAC])));
    endfunction

    // Coefficient product, floored by 28 bits, no saturation.
    function automatic logic signed [35:0] mulc(input q30_t c, input q30_t a);
        logic signed [63:0] p;
        p = 64'(c) * 64'(a);
        return $signed(p[63:COEF_FRAC]);
    endfunction

endpackage

// ===== rtl/lpu_div.sv =====
// Pipelined restoring divider: signed numerator over a Q2.30 divisor, quotient saturated.
module lpu_div #(
    parameter int NUM_W = lpu_pkg::PASS_NUM_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [NUM_W-1:0] in_num,
    input  lpu_pkg::q30_t           in_den,
    output logic                    out_valid,
    output lpu_pkg::q30_t           out_quo
);

    localparam int QW = lpu_pkg::QUO_W;

    // Magnitude stage.
    logic             v0_reg;
    logic             neg0_reg;
    logic [NUM_W-1:0] un0_reg;
    logic [QW-1:0]    ud0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg  <= in_num[NUM_W-1] ^ in_den[QW-1];
            un0_reg   <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
            ud0_reg   <= in_den[QW-1] ? QW'(-in_den) : QW'(in_den);
        end
    end

    // Iteration state; index 0 is the range stage, index QW holds the full quotient.
    logic          vld_reg  [0:QW];
    logic          neg_reg  [0:QW];
    logic          zero_reg [0:QW];
    logic          ovf_reg  [0:QW];
    logic [QW-1:0] ud_reg   [0:QW];
    logic [QW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] low_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];

    // Range stage: a quotient of 2^32 or more saturates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0]  <= neg0_reg;
            zero_reg[0] <= (un0_reg == '0);
            ovf_reg[0]  <= (QW'(un0_reg[NUM_W-1:QW]) >= ud0_reg);
            ud_reg[0]   <= ud0_reg;
            rem_reg[0]  <= QW'(un0_reg[NUM_W-1:QW]);
            low_reg[0]  <= un0_reg[QW-1:0];
            quo_reg[0]  <= '0;
        end
    end

    // One quotient bit per stage.
    for (genvar i = 0; i < QW; i++) begin : g_bit
        logic [QW:0] rs;
        logic        ge;

        assign rs = {rem_reg[i], low_reg[i][QW-1]};
        assign ge = (rs >= {1'b0, ud_reg[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                ovf_reg[i+1]  <= ovf_reg[i];
                ud_reg[i+1]   <= ud_reg[i];
                rem_reg[i+1]  <= ge ? QW'(rs - {1'b0, ud_reg[i]}) : rs[QW-1:0];
                low_reg[i+1]  <= {low_reg[i][QW-2:0], 1'b0};
                quo_reg[i+1]  <= {quo_reg[i][QW-2:0], ge};
            end
        end
    end

    // Sign and saturation stage. A zero divisor is positive, so the quotient sign
    // then equals the numerator sign.
    logic          valid_reg;
    lpu_pkg::q30_t quo_out_reg;
    lpu_pkg::q30_t quo_next;
    logic [QW-1:0] q;

    assign q = quo_reg[QW];

    always_comb begin
        if (zero_reg[QW]) begin
            quo_next = '0;
        end else if (ovf_reg[QW]) begin
            quo_next = neg_reg[QW] ? lpu_pkg::Q30_MIN : lpu_pkg::Q30_MAX;
        end else if (neg_reg[QW]) begin
            quo_next = (q[QW-1] && (q[QW-2:0] != '0)) ? lpu_pkg::Q30_MIN : $signed(QW'(-q));
        end else begin
            quo_next = q[QW-1] ? lpu_pkg::Q30_MAX : $signed(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_out_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_quo   = quo_out_reg;

endmodule

// ===== rtl/lpu_pass.sv =====
// One refinement pass: distortion polynomial stages followed by two pipelined dividers.
module lpu_pass (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  lpu_pkg::coef_t coef,
    input  lpu_pkg::pt_t   in_pt,
    output lpu_pkg::pt_t   out_pt
);

    localparam int LAT = lpu_pkg::DIV_LAT;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Valid bits of the polynomial stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_pt.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage 1: squares and cross product.
    lpu_pkg::q30_t xx1_reg, yy1_reg, xy1_reg, x01_reg, y01_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xx1_reg <= lpu_pkg::mul30(in_pt.x, in_pt.x);
            yy1_reg <= lpu_pkg::mul30(in_pt.y, in_pt.y);
            xy1_reg <= lpu_pkg::mul30(in_pt.x, in_pt.y);
            x01_reg <= in_pt.x0;
            y01_reg <= in_pt.y0;
        end
    end

    // Stage 2: squared radius and doubled cross product.
    lpu_pkg::q30_t xx2_reg, yy2_reg, xy22_reg, r22_reg, x02_reg, y02_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xx2_reg  <= xx1_reg;
            yy2_reg  <= yy1_reg;
            xy22_reg <= lpu_pkg::sat30(40'(xy1_reg) <<< 1);
            r22_reg  <= lpu_pkg::sat30(40'(xx1_reg) + 40'(yy1_reg));
            x02_reg  <= x01_reg;
            y02_reg  <= y01_reg;
        end
    end

    // Stage 3: tangential arguments and the k2 term.
    lpu_pkg::q30_t     a3_reg, b3_reg, r23_reg, xy23_reg, x03_reg, y03_reg;
    logic signed [35:0] u3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg   <= lpu_pkg::sat30(40'(r22_reg) + (40'(xx2_reg) <<< 1));
            b3_reg   <= lpu_pkg::sat30(40'(r22_reg) + (40'(yy2_reg) <<< 1));
            u3_reg   <= lpu_pkg::mulc(coef.k2, r22_reg);
            r23_reg  <= r22_reg;
            xy23_reg <= xy22_reg;
            x03_reg  <= x02_reg;
            y03_reg  <= y02_reg;
        end
    end

    // Stage 4: radial partial sum and the four tangential products.
    lpu_pkg::q30_t      t4_reg, r24_reg, x04_reg, y04_reg;
    logic signed [35:0] m1_reg, m2_reg, m3_reg, m4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t4_reg  <= lpu_pkg::sat30(40'(u3_reg) + (40'(coef.k1) <<< 2));
            m1_reg  <= lpu_pkg::mulc(coef.p1, xy23_reg);
            m2_reg  <= lpu_pkg::mulc(coef.p2, a3_reg);
            m3_reg  <= lpu_pkg::mulc(coef.p1, b3_reg);
            m4_reg  <= lpu_pkg::mulc(coef.p2, xy23_reg);
            r24_reg <= r23_reg;
            x04_reg <= x03_reg;
            y04_reg <= y03_reg;
        end
    end

    // Stage 5: radial product and tangential offsets.
    lpu_pkg::q30_t fm5_reg, dx5_reg, dy5_reg, x05_reg, y05_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            fm5_reg <= lpu_pkg::mul30(t4_reg, r24_reg);
            dx5_reg <= lpu_pkg::sat30(40'(m1_reg) + 40'(m2_reg));
            dy5_reg <= lpu_pkg::sat30(40'(m3_reg) + 40'(m4_reg));
            x05_reg <= x04_reg;
            y05_reg <= y04_reg;
        end
    end

    // Stage 6: radial factor and the corrected dividends.
    lpu_pkg::q30_t f6_reg, nx6_reg, ny6_reg, x06_reg, y06_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            f6_reg  <= lpu_pkg::sat30(40'sd1073741824 + 40'(fm5_reg));
            nx6_reg <= lpu_pkg::sat30(40'(x05_reg) - 40'(dx5_reg));
            ny6_reg <= lpu_pkg::sat30(40'(y05_reg) - 40'(dy5_reg));
            x06_reg <= x05_reg;
            y06_reg <= y05_reg;
        end
    end

    // Division by the radial factor.
    logic          vx, vy;
    lpu_pkg::q30_t qx, qy;

    lpu_div #(.NUM_W(lpu_pkg::PASS_NUM_W)) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    ($signed({nx6_reg, 30'd0})),
        .in_den    (f6_reg),
        .out_valid (vx),
        .out_quo   (qx)
    );

    lpu_div #(.NUM_W(lpu_pkg::PASS_NUM_W)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    ($signed({ny6_reg, 30'd0})),
        .in_den    (f6_reg),
        .out_valid (vy),
        .out_quo   (qy)
    );

    // The normalized distorted point travels alongside the dividers.
    lpu_pkg::q30_t x0d_reg [0:LAT-1];
    lpu_pkg::q30_t y0d_reg [0:LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            x0d_reg[0] <= x06_reg;
            y0d_reg[0] <= y06_reg;
            for (int i = 1; i < LAT; i++) begin
                x0d_reg[i] <= x0d_reg[i-1];
                y0d_reg[i] <= y0d_reg[i-1];
            end
        end
    end

    assign out_pt.valid = vx & vy;
    assign out_pt.x     = qx;
    assign out_pt.y     = qy;
    assign out_pt.x0    = x0d_reg[LAT-1];
    assign out_pt.y0    = y0d_reg[LAT-1];

endmodule

// ===== rtl/lpu_pixel.sv =====
// Maps a normalized point back to pixels and saturates it to signed Q13.4.
module lpu_pixel (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  lpu_pkg::pt_t       in_pt,
    input  logic [23:0]        focal_x,
    input  logic [23:0]        focal_y,
    input  logic [23:0]        center_x,
    input  logic [23:0]        center_y,
    output logic               out_valid,
    output logic signed [17:0] out_col,
    output logic signed [17:0] out_row,
    output logic               out_clipped
);

    localparam logic signed [21:0] OUT_MAX = 22'sd131071;
    localparam logic signed [21:0] OUT_MIN = -22'sd131072;

    // Stage 1: scale by the focal lengths, floored to Q16.10.
    logic               v1_reg;
    logic signed [26:0] sx1_reg, sy1_reg;
    logic signed [56:0] px, py;

    assign px = 57'(in_pt.x) * $signed(57'(focal_x));
    assign py = 57'(in_pt.y) * $signed(57'(focal_y));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_pt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx1_reg <= px[56:30];
            sy1_reg <= py[56:30];
        end
    end

    // Stage 2: add the principal point, floor to Q13.4 and saturate.
    logic signed [27:0] cq10, rq10;
    logic signed [21:0] cq4, rq4;
    logic signed [17:0] col_next, row_next;
    logic               cclip, rclip;

    assign cq10 = 28'(sx1_reg) + $signed(28'(center_x));
    assign rq10 = 28'(sy1_reg) + $signed(28'(center_y));
    assign cq4  = cq10[27:6];
    assign rq4  = rq10[27:6];

    always_comb begin
        cclip = 1'b1;
        if (cq4 > OUT_MAX) begin
            col_next = OUT_MAX[17:0];
        end else if (cq4 < OUT_MIN) begin
            col_next = OUT_MIN[17:0];
        end else begin
            col_next = cq4[17:0];
            cclip    = 1'b0;
        end
        rclip = 1'b1;
        if (rq4 > OUT_MAX) begin
            row_next = OUT_MAX[17:0];
        end else if (rq4 < OUT_MIN) begin
            row_next = OUT_MIN[17:0];
        end else begin
            row_next = rq4[17:0];
            rclip    = 1'b0;
        end
    end

    logic               valid_reg;
    logic signed [17:0] col_reg, row_reg;
    logic               clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            clip_reg <= cclip | rclip;
        end
    end

    assign out_valid   = valid_reg;
    assign out_col     = col_reg;
    assign out_row     = row_reg;
    assign out_clipped = clip_reg;

endmodule

// ===== rtl/lens_point_undistort_unit.sv =====
// Top level of the lens point undistortion unit: configuration, normalization and pass chain.
// Takes one distorted pixel point per cycle and returns its undistorted position. Every point
// goes through normalization (a 35-stage divider), PASSES refinement passes of 41 stages each
// (six polynomial stages and a 35-stage divider, one quotient bit per stage) and a two-stage
// pixel mapping. The pipeline holds as many points as it has stages and sustains one point per
// cycle; when the result output is stalled the whole pipeline holds. Configuration is written
// through the cfg channel, which is always ready; the user must write it only while no point
// is in flight, and the block itself does not enforce this.
module lens_point_undistort_unit #(
    parameter int PASSES = lpu_pkg::PASSES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_col [15:0], pixel_row [31:16]
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // fixed_col [17:0], fixed_row [35:18], zero fill [39:36]
    output logic [0:0]  m_tuser,   // clipped [0]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [23:0]    focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    lpu_pkg::coef_t coef_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= lpu_pkg::FOCAL_RESET;
            focal_y_reg  <= lpu_pkg::FOCAL_RESET;
            center_x_reg <= '0;
            center_y_reg <= '0;
            coef_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lpu_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data[23:0];
                lpu_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data[23:0];
                lpu_pkg::REG_CENTER_X: center_x_reg <= cfg_data[23:0];
                lpu_pkg::REG_CENTER_Y: center_y_reg <= cfg_data[23:0];
                lpu_pkg::REG_K1:       coef_reg.k1  <= cfg_data;
                lpu_pkg::REG_K2:       coef_reg.k2  <= cfg_data;
                lpu_pkg::REG_P1:       coef_reg.p1  <= cfg_data;
                lpu_pkg::REG_P2:       coef_reg.p2  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished result is waiting.
    logic adv;
    logic out_valid;

    assign adv      = !out_valid || m_tready;
    assign s_tready = adv;

    // Normalization: (pixel - center) / focal in Q2.30.
    logic [15:0]        col_in, row_in;
    logic signed [24:0] dcol, drow;

    assign col_in = s_tdata[15:0];
    assign row_in = s_tdata[31:16];
    assign dcol   = $signed({3'b000, col_in, 6'd0}) - $signed({1'b0, center_x_reg});
    assign drow   = $signed({3'b000, row_in, 6'd0}) - $signed({1'b0, center_y_reg});

    lpu_pkg::pt_t  chain [0:PASSES];
    logic          nvx, nvy;
    lpu_pkg::q30_t nx0, ny0;

    lpu_div #(.NUM_W(lpu_pkg::NORM_NUM_W)) u_norm_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_num    ($signed({dcol, 30'd0})),
        .in_den    ($signed({8'd0, focal_x_reg})),
        .out_valid (nvx),
        .out_quo   (nx0)
    );

    lpu_div #(.NUM_W(lpu_pkg::NORM_NUM_W)) u_norm_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .in_num    ($signed({drow, 30'd0})),
        .in_den    ($signed({8'd0, focal_y_reg})),
        .out_valid (nvy),
        .out_quo   (ny0)
    );

    assign chain[0].valid = nvx & nvy;
    assign chain[0].x     = nx0;
    assign chain[0].y     = ny0;
    assign chain[0].x0    = nx0;
    assign chain[0].y0    = ny0;

    // Refinement passes.
    for (genvar p = 0; p < PASSES; p++) begin : g_pass
        lpu_pass u_pass (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .coef    (coef_reg),
            .in_pt   (chain[p]),
            .out_pt  (chain[p+1])
        );
    end

    // Back to pixels; the final register is the result output.
    logic signed [17:0] fixed_col, fixed_row;
    logic               clipped;

    lpu_pixel u_pixel (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_pt       (chain[PASSES]),
        .focal_x     (focal_x_reg),
        .focal_y     (focal_y_reg),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .out_valid   (out_valid),
        .out_col     (fixed_col),
        .out_row     (fixed_row),
        .out_clipped (clipped)
    );

    assign m_tvalid   = out_valid;
    assign m_tdata    = {4'd0, fixed_row, fixed_col};
    assign m_tuser[0] = clipped;

endmodule
